// ===== rtl/gss_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Gauss-Seidel solver.
package gss_pkg;

    localparam int VALUE_WIDTH     = 48;
    localparam int FRAC_BITS       = 32;
    localparam int HALF_WIDTH      = VALUE_WIDTH / 2;
    localparam int PROD_WIDTH      = 2 * VALUE_WIDTH;
    localparam int TRUNC_WIDTH     = PROD_WIDTH - FRAC_BITS;
    localparam int QUOT_WIDTH      = VALUE_WIDTH + FRAC_BITS;
    localparam int DEF_MAX_ORDER   = 16;

    localparam int ACTION_WIDTH    = 2;
    localparam int ROW_WIDTH       = 4;
    localparam int STATUS_WIDTH    = 2;
    localparam int SWEEP_WIDTH     = 10;
    localparam int ORDER_WIDTH     = 5;
    localparam int TOL_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(1);
    localparam logic [SWEEP_WIDTH-1:0] LIMIT_RESET = SWEEP_WIDTH'(500);
    localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = TOL_WIDTH'(2);

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_MATRIX = 2'd0,
        ACT_RHS    = 2'd1,
        ACT_SOLVE  = 2'd2
    } t_action;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_CONVERGED = 2'd0,
        ST_ZERO_DIAG = 2'd1,
        ST_LIMIT     = 2'd2
    } t_status;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ORDER     = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_TOLERANCE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Magnitude of a signed value; the most negative value maps to 2^(W-1).
    function automatic logic [VALUE_WIDTH-1:0] vmag(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] u;
        u = v;
        return v[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // Apply a sign to a magnitude and clamp to the value range.
    function automatic logic signed [VALUE_WIDTH-1:0] from_mag(input logic neg,
                                                             input logic [TRUNC_WIDTH-1:0] m);
        logic [VALUE_WIDTH-1:0] low;
        low = m[VALUE_WIDTH-1:0];
        if (m >= (TRUNC_WIDTH'(1) << (VALUE_WIDTH - 1))) begin
            return neg ? VMIN : VMAX;
        end
        return neg ? (~low + 1'b1) : low;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] sat_add(input logic signed [VALUE_WIDTH-1:0] a,
                                                            input logic signed [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] sat_sub(input logic signed [VALUE_WIDTH-1:0] a,
                                                            input logic signed [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/gss_in_if.sv =====
// Input channel carrying load and solve items.
interface gss_in_if;
    import gss_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [ACTION_WIDTH-1:0]        action;
    logic [ROW_WIDTH-1:0]           row;
    logic [ROW_WIDTH-1:0]           col;
    logic signed [VALUE_WIDTH-1:0]  value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

// ===== rtl/gss_out_if.sv =====
// Output channel carrying solution entries and status results.
interface gss_out_if;
    import gss_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [ROW_WIDTH-1:0]           index;
    logic signed [VALUE_WIDTH-1:0]  solution;
    logic [STATUS_WIDTH-1:0]        status;
    logic [SWEEP_WIDTH-1:0]         sweeps;
    logic                           last;

    modport source (output valid, index, solution, status, sweeps, last, input ready);
    modport sink   (input valid, index, solution, status, sweeps, last, output ready);
endinterface

// ===== rtl/gss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fixed-point quotient.
module gss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gss_pkg::VALUE_WIDTH-1:0]   i_dividend,
    input  logic [gss_pkg::VALUE_WIDTH-1:0]   i_divisor,
    output gss_pkg::t_div_status              o_status,
    output logic [gss_pkg::QUOT_WIDTH-1:0]    o_quotient
);
    import gss_pkg::*;

    localparam int CW = $clog2(QUOT_WIDTH);

    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [QUOT_WIDTH-1:0]  r_num;
    logic [QUOT_WIDTH-1:0]  r_q;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [VALUE_WIDTH:0]   shifted;
    logic                   ge;

    // The remainder stays below the divisor, so one extra bit holds the shift.
    assign shifted = {r_rem, r_num[QUOT_WIDTH-1]};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_num <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_q   <= '0;
            r_cnt <= CW'(QUOT_WIDTH - 1);
        end else if (r_busy) begin
            r_rem <= ge ? VALUE_WIDTH'(shifted - {1'b0, r_div}) : shifted[VALUE_WIDTH-1:0];
            r_num <= r_num << 1;
            r_q   <= {r_q[QUOT_WIDTH-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_q;
endmodule

// ===== rtl/gauss_seidel_linear_solver_core.sv =====
// Gauss-Seidel solver core: load items fill A and b, a solve item sweeps x in place.
// A load item is written when it is accepted; a solve first checks every diagonal entry,
// then sweeps until convergence or the limit, and emits the solution entries or a status.
// Throughput: loads transfer one per cycle while idle; the serial divider (one quotient
// bit a cycle) and the four-step partial-product multiplier set the sweep time.
// Reset: synchronous active low; registers return to order 1, limit 500, tolerance 2.
// The matrix and right-hand side memories are not cleared and need no clearing pass.
module gauss_seidel_linear_solver_core #(
    parameter int MAX_ORDER = gss_pkg::DEF_MAX_ORDER
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    gss_in_if.sink                                i_in,
    gss_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [gss_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [gss_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);
    import gss_pkg::*;

    // Row and column indexes each take IW bits; the matrix memory is addressed by {row, col}.
    localparam int IW    = $clog2(MAX_ORDER);
    localparam int MDEP  = 2 ** (2 * IW);
    localparam int TPW   = TOL_WIDTH + HALF_WIDTH;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_DCHK_RD   = 16'h0002,
        S_DCHK      = 16'h0004,
        S_TERM_RD   = 16'h0008,
        S_TERM_MAG  = 16'h0010,
        S_MUL       = 16'h0020,
        S_ACC       = 16'h0040,
        S_DIAG_RD   = 16'h0080,
        S_DIV_START = 16'h0100,
        S_DIV_WAIT  = 16'h0200,
        S_WB        = 16'h0400,
        S_TOL0      = 16'h0800,
        S_TOL1      = 16'h1000,
        S_CMP       = 16'h2000,
        S_EMIT_RD   = 16'h4000,
        S_EMIT      = 16'h8000
    } t_state;

    // Status results reuse S_EMIT with a pending status code other than converged.
    t_state r_state, n_state;

    logic [ORDER_WIDTH-1:0]        r_order;
    logic [SWEEP_WIDTH-1:0]        r_limit;
    logic [TOL_WIDTH-1:0]          r_tol;

    logic [IW-1:0]                 r_last, n_last;
    logic [SWEEP_WIDTH-1:0]        r_lim_eff, n_lim_eff;
    logic [IW-1:0]                 r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [VALUE_WIDTH-1:0]        r_ma, n_ma, r_mx, n_mx;
    logic                          r_neg, n_neg;
    logic [1:0]                    r_mstep, n_mstep;
    logic [PROD_WIDTH-1:0]         r_prod, n_prod;
    logic signed [VALUE_WIDTH-1:0] r_old, n_old;
    logic                          r_qneg, n_qneg;
    logic [VALUE_WIDTH-1:0]        r_mc, n_mc, r_mm, n_mm;
    logic [SWEEP_WIDTH-1:0]        r_sweep, n_sweep;
    logic [TPW-1:0]                r_tlo, n_tlo, r_thi, n_thi;
    t_status                       r_pend, n_pend;
    logic [MAX_ORDER-1:0]          r_xvalid, n_xvalid;

    logic                          r_out_valid, n_out_valid;
    logic [ROW_WIDTH-1:0]          r_out_index, n_out_index;
    logic signed [VALUE_WIDTH-1:0] r_out_sol, n_out_sol;
    logic [STATUS_WIDTH-1:0]       r_out_status, n_out_status;
    logic [SWEEP_WIDTH-1:0]        r_out_sweeps, n_out_sweeps;
    logic                          r_out_last, n_out_last;

    // Memories and their registered read data.
    logic signed [VALUE_WIDTH-1:0] mat_mem [MDEP];
    logic signed [VALUE_WIDTH-1:0] rhs_mem [MAX_ORDER];
    logic signed [VALUE_WIDTH-1:0] x_mem   [MAX_ORDER];
    logic signed [VALUE_WIDTH-1:0] r_mat_q, r_rhs_q, r_x_q;
    logic                          r_xv_q;

    logic                          in_xfer;
    logic                          mat_we, rhs_we, x_we;
    logic [2*IW-1:0]               mat_wa, mat_ra;
    logic [IW-1:0]                 x_ra;
    logic signed [VALUE_WIDTH-1:0] x_wd;
    logic                          row_ok, col_ok;
    logic                          slot_free, out_load;

    logic                          div_start;
    logic [VALUE_WIDTH-1:0]        div_dividend, div_divisor;
    t_div_status                   div_st;
    logic [QUOT_WIDTH-1:0]         div_q;

    logic [HALF_WIDTH-1:0]         mul_a, mul_x;
    logic [2*HALF_WIDTH-1:0]       mul_pp;
    logic [PROD_WIDTH-1:0]         mul_term;
    logic signed [VALUE_WIDTH-1:0] prod_val, resid, q_val, x_cur;
    logic [VALUE_WIDTH:0]          diff;
    logic [VALUE_WIDTH-1:0]        change, q_mag;
    logic [QUOT_WIDTH-1:0]         tol_rhs, tol_lhs;
    logic [TRUNC_WIDTH-1:0]        q_trunc;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign slot_free = !r_out_valid || o_out.ready;

    assign row_ok = 32'(i_in.row) < MAX_ORDER;
    assign col_ok = 32'(i_in.col) < MAX_ORDER;
    assign mat_we = in_xfer && (t_action'(i_in.action) == ACT_MATRIX) && row_ok && col_ok;
    assign rhs_we = in_xfer && (t_action'(i_in.action) == ACT_RHS) && row_ok;
    assign mat_wa = {IW'(i_in.row), IW'(i_in.col)};
    assign mat_ra = (r_state == S_TERM_RD) ? {r_i, r_j} : {r_i, r_i};
    assign x_ra   = (r_state == S_TERM_RD) ? r_j :
                    ((r_state == S_EMIT_RD) || (r_state == S_EMIT)) ? r_k : r_i;
    assign x_cur  = r_xv_q ? r_x_q : '0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_limit <= LIMIT_RESET;
            r_tol   <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORDER:     r_order <= i_cfg_data[ORDER_WIDTH-1:0];
                CFG_LIMIT:     r_limit <= i_cfg_data[SWEEP_WIDTH-1:0];
                CFG_TOLERANCE: r_tol   <= i_cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            mat_mem[mat_wa] <= i_in.value;
        end
        r_mat_q <= mat_mem[mat_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rhs_we) begin
            rhs_mem[IW'(i_in.row)] <= i_in.value;
        end
        r_rhs_q <= rhs_mem[r_i];
    end

    // The estimate is cleared at solve start through its valid bits, not by a sweep.
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[r_i] <= x_wd;
        end
        r_x_q  <= x_mem[x_ra];
        r_xv_q <= r_xvalid[x_ra];
    end

    gss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_st),
        .o_quotient (div_q)
    );

    // Datapath pieces shared by the state machine below.
    always_comb begin
        mul_a  = r_mstep[1] ? r_ma[VALUE_WIDTH-1:HALF_WIDTH] : r_ma[HALF_WIDTH-1:0];
        mul_x  = r_mstep[0] ? r_mx[VALUE_WIDTH-1:HALF_WIDTH] : r_mx[HALF_WIDTH-1:0];
        mul_pp = mul_a * mul_x;
        case (r_mstep)
            2'd0:    mul_term = PROD_WIDTH'(mul_pp);
            2'd3:    mul_term = PROD_WIDTH'(mul_pp) << (2 * HALF_WIDTH);
            default: mul_term = PROD_WIDTH'(mul_pp) << HALF_WIDTH;
        endcase
        // Product magnitude is truncated toward zero to the fraction width.
        prod_val     = from_mag(r_neg, r_prod[PROD_WIDTH-1:FRAC_BITS]);
        resid        = sat_sub(r_rhs_q, r_acc);
        div_dividend = vmag(resid);
        div_divisor  = vmag(r_mat_q);
        q_trunc      = (|div_q[QUOT_WIDTH-1:TRUNC_WIDTH]) ? '1 : div_q[TRUNC_WIDTH-1:0];
        q_val        = from_mag(r_qneg, q_trunc);
        diff         = {q_val[VALUE_WIDTH-1], q_val} - {r_old[VALUE_WIDTH-1], r_old};
        change       = diff[VALUE_WIDTH] ? VALUE_WIDTH'(~diff + 1'b1) : diff[VALUE_WIDTH-1:0];
        q_mag        = vmag(q_val);
        tol_rhs      = QUOT_WIDTH'({r_thi, {HALF_WIDTH{1'b0}}}) + QUOT_WIDTH'(r_tlo);
        tol_lhs      = {r_mc, {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        n_state      = r_state;
        n_last       = r_last;
        n_lim_eff    = r_lim_eff;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_acc        = r_acc;
        n_ma         = r_ma;
        n_mx         = r_mx;
        n_neg        = r_neg;
        n_mstep      = r_mstep;
        n_prod       = r_prod;
        n_old        = r_old;
        n_qneg       = r_qneg;
        n_mc         = r_mc;
        n_mm         = r_mm;
        n_sweep      = r_sweep;
        n_tlo        = r_tlo;
        n_thi        = r_thi;
        n_pend       = r_pend;
        n_xvalid     = r_xvalid;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_index  = r_out_index;
        n_out_sol    = r_out_sol;
        n_out_status = r_out_status;
        n_out_sweeps = r_out_sweeps;
        n_out_last   = r_out_last;
        div_start    = 1'b0;
        x_we         = 1'b0;
        x_wd         = q_val;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (t_action'(i_in.action) == ACT_SOLVE)) begin
                    // Effective order and limit are fixed for the whole solve.
                    if (r_order == '0) begin
                        n_last = '0;
                    end else if (32'(r_order) > MAX_ORDER) begin
                        n_last = IW'(MAX_ORDER - 1);
                    end else begin
                        n_last = IW'(r_order - 1'b1);
                    end
                    n_lim_eff = (r_limit == '0) ? SWEEP_WIDTH'(1) : r_limit;
                    n_xvalid  = '0;
                    n_sweep   = '0;
                    n_mc      = '0;
                    n_mm      = '0;
                    n_i       = '0;
                    n_state   = S_DCHK_RD;
                end
            end
            S_DCHK_RD: n_state = S_DCHK;
            S_DCHK: begin
                if (r_mat_q == '0) begin
                    n_pend  = ST_ZERO_DIAG;
                    n_state = S_EMIT;
                end else if (r_i == r_last) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = S_TERM_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_DCHK_RD;
                end
            end
            S_TERM_RD: begin
                // The diagonal term is left out of the sum.
                if (r_j == r_i) begin
                    if (r_j == r_last) begin
                        n_state = S_DIAG_RD;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_state = S_TERM_MAG;
                end
            end
            S_TERM_MAG: begin
                n_ma    = vmag(r_mat_q);
                n_mx    = vmag(x_cur);
                n_neg   = r_mat_q[VALUE_WIDTH-1] != x_cur[VALUE_WIDTH-1];
                n_mstep = '0;
                n_prod  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = r_prod + mul_term;
                n_mstep = r_mstep + 1'b1;
                if (r_mstep == 2'd3) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc = sat_add(r_acc, prod_val);
                if (r_j == r_last) begin
                    n_state = S_DIAG_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_TERM_RD;
                end
            end
            S_DIAG_RD: n_state = S_DIV_START;
            S_DIV_START: begin
                div_start = 1'b1;
                n_old     = x_cur;
                n_qneg    = resid[VALUE_WIDTH-1] != r_mat_q[VALUE_WIDTH-1];
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_st.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                x_we          = 1'b1;
                n_xvalid[r_i] = 1'b1;
                if (change > r_mc) begin
                    n_mc = change;
                end
                if (q_mag > r_mm) begin
                    n_mm = q_mag;
                end
                if (r_i == r_last) begin
                    n_sweep = r_sweep + 1'b1;
                    n_state = S_TOL0;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = S_TERM_RD;
                end
            end
            S_TOL0: begin
                n_tlo   = r_tol * r_mm[HALF_WIDTH-1:0];
                n_state = S_TOL1;
            end
            S_TOL1: begin
                n_thi   = r_tol * r_mm[VALUE_WIDTH-1:HALF_WIDTH];
                n_state = S_CMP;
            end
            S_CMP: begin
                // Converged when max change * 2^32 <= tolerance * max magnitude.
                if (tol_lhs <= tol_rhs) begin
                    n_pend  = ST_CONVERGED;
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else if (r_sweep >= r_lim_eff) begin
                    n_pend  = ST_LIMIT;
                    n_state = S_EMIT;
                end else begin
                    n_i     = '0;
                    n_j     = '0;
                    n_acc   = '0;
                    n_mc    = '0;
                    n_mm    = '0;
                    n_state = S_TERM_RD;
                end
            end
            S_EMIT_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) begin
                    out_load     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    unique case (r_pend)
                        ST_ZERO_DIAG: begin
                            n_out_index  = ROW_WIDTH'(r_i);
                            n_out_sol    = '0;
                            n_out_sweeps = '0;
                            n_out_last   = 1'b1;
                            n_state      = S_IDLE;
                        end
                        ST_LIMIT: begin
                            n_out_index  = '0;
                            n_out_sol    = '0;
                            n_out_sweeps = r_sweep;
                            n_out_last   = 1'b1;
                            n_state      = S_IDLE;
                        end
                        default: begin
                            n_out_index  = ROW_WIDTH'(r_k);
                            n_out_sol    = x_cur;
                            n_out_sweeps = r_sweep;
                            n_out_last   = (r_k == r_last);
                            if (r_k == r_last) begin
                                n_state = S_IDLE;
                            end else begin
                                n_k     = r_k + 1'b1;
                                n_state = S_EMIT_RD;
                            end
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_xvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_xvalid    <= n_xvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_lim_eff    <= n_lim_eff;
        r_i          <= n_i;
        r_j          <= n_j;
        r_k          <= n_k;
        r_acc        <= n_acc;
        r_ma         <= n_ma;
        r_mx         <= n_mx;
        r_neg        <= n_neg;
        r_mstep      <= n_mstep;
        r_prod       <= n_prod;
        r_old        <= n_old;
        r_qneg       <= n_qneg;
        r_mc         <= n_mc;
        r_mm         <= n_mm;
        r_sweep      <= n_sweep;
        r_tlo        <= n_tlo;
        r_thi        <= n_thi;
        r_pend       <= n_pend;
        r_out_index  <= n_out_index;
        r_out_sol    <= n_out_sol;
        r_out_status <= n_out_status;
        r_out_sweeps <= n_out_sweeps;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.index    = r_out_index;
    assign o_out.solution = r_out_sol;
    assign o_out.status   = r_out_status;
    assign o_out.sweeps   = r_out_sweeps;
    assign o_out.last     = r_out_last;

`ifndef SYNTHESIS
    // A solve start clears every estimate entry before the first sweep reads it.
    a_clear_on_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.action == ACT_SOLVE) |=> (r_xvalid == '0))
        else $error("estimate valid bits not cleared at solve start");

    // The divider is never restarted while it is still working.
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    // A result is only placed in the output register when it is empty or draining.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");
`endif
endmodule
